// File: src/nns_pkg.sv
package nns_pkg;

    // Frame store geometry.
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field and register widths.
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 3 * CHAN_W;
    localparam int DIM_W      = 9;
    localparam int FACTOR_W   = 12;
    localparam int FRAC_W     = 8;
    localparam int POS_W      = 12;
    localparam int OUT_W      = POS_W + 1;
    localparam int OUT_LIMIT  = 4096;
    localparam int DIVIDEND_W = POS_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int INDEX_W    = 2;
    localparam int WDATA_W    = FACTOR_W;

    // Register indexes of the configuration port.
    typedef enum logic [INDEX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_SCALE_FACTOR  = 2'd2
    } reg_index_t;

    // Fetch sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_DIV,
        S_COL_DIV,
        S_ADDR,
        S_READ,
        S_EMIT
    } state_t;

    // Handshake between the sequencer and the shared divider.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [FACTOR_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: src/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler.
// An item is taken at a rising edge with start high and busy low. With
// operation low the item loads the next source pixel of the raster into the
// frame store; the load is done in that same edge and busy stays low, so loads
// can follow one per cycle while no fetch is in progress. With operation high
// the item fetches the next pixel of the scaled image: busy rises, the shared
// restoring divider computes the 20-bit row quotient and then the column
// quotient, the address is registered, the frame store is read, and then done
// is high for exactly one cycle with the pixel, its row and column and
// last_pixel. Busy falls at the edge that takes the result, so no new item is
// taken while a fetch is in progress. A fetch on an empty scaled image gives
// no result and leaves busy low.
// Configuration registers are written through wr_en, wr_index and wr_data,
// one per cycle; the user must write them only while no fetch is in
// progress, which the block does not enforce. Reset clears the load pointer
// and the output counters and sets width, height and factor to 256; the frame
// store keeps no reset and must be loaded before it is fetched from. The
// receiver cannot stall: each result is taken in the cycle that done is high.
module nearest_neighbor_image_scaler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [nns_pkg::CHAN_W-1:0]     in_red,
    input  logic [nns_pkg::CHAN_W-1:0]     in_green,
    input  logic [nns_pkg::CHAN_W-1:0]     in_blue,
    input  logic                           wr_en,
    input  logic [nns_pkg::INDEX_W-1:0]    wr_index,
    input  logic [nns_pkg::WDATA_W-1:0]    wr_data,
    output logic                           done,
    output logic [nns_pkg::CHAN_W-1:0]     out_red,
    output logic [nns_pkg::CHAN_W-1:0]     out_green,
    output logic [nns_pkg::CHAN_W-1:0]     out_blue,
    output logic [nns_pkg::POS_W-1:0]      out_row,
    output logic [nns_pkg::POS_W-1:0]      out_col,
    output logic                           last_pixel
);

    localparam int PROD_W  = 2 * nns_pkg::DIM_W;
    localparam int SCALE_W = nns_pkg::DIM_W + nns_pkg::FACTOR_W;

    nns_pkg::state_t state_reg;
    nns_pkg::state_t state_next;

    logic [nns_pkg::DIM_W-1:0]    source_width_reg;
    logic [nns_pkg::DIM_W-1:0]    source_height_reg;
    logic [nns_pkg::FACTOR_W-1:0] scale_factor_reg;

    logic [nns_pkg::ADDR_W-1:0]   load_ptr_reg;
    logic [nns_pkg::POS_W-1:0]    emit_row_reg;
    logic [nns_pkg::POS_W-1:0]    emit_col_reg;
    logic [nns_pkg::POS_W-1:0]    cur_row_reg;
    logic [nns_pkg::POS_W-1:0]    cur_col_reg;
    logic                         last_reg;
    logic [nns_pkg::DIM_W-1:0]    src_row_reg;
    logic [nns_pkg::DIM_W-1:0]    src_col_reg;
    logic [nns_pkg::ADDR_W-1:0]   read_addr_reg;

    logic [nns_pkg::DIM_W-1:0]    width_eff;
    logic [nns_pkg::DIM_W-1:0]    height_eff;
    logic [nns_pkg::FACTOR_W-1:0] factor_eff;
    logic [PROD_W-1:0]            total;
    logic [SCALE_W-1:0]           width_prod;
    logic [SCALE_W-1:0]           height_prod;
    logic [nns_pkg::OUT_W-1:0]    scaled_w;
    logic [nns_pkg::OUT_W-1:0]    scaled_h;

    logic                         accept;
    logic                         load_go;
    logic                         fetch_go;
    logic [nns_pkg::ADDR_W-1:0]   ptr_eff;
    logic [PROD_W-1:0]            ptr_inc;
    logic [nns_pkg::ADDR_W-1:0]   ptr_next;

    logic                         restart;
    logic [nns_pkg::POS_W-1:0]    row_start;
    logic [nns_pkg::POS_W-1:0]    col_start;
    logic [nns_pkg::OUT_W-1:0]    row_inc;
    logic [nns_pkg::OUT_W-1:0]    col_inc;
    logic [nns_pkg::POS_W-1:0]    row_after;
    logic [nns_pkg::POS_W-1:0]    col_after;
    logic                         last_now;

    logic [nns_pkg::DIM_W-1:0]    quo_row_sat;
    logic [nns_pkg::DIM_W-1:0]    quo_col_sat;
    logic [PROD_W-1:0]            addr_full;

    logic                         div_sel_col;
    logic                         ram_re;
    nns_pkg::div_req_t            div_req;
    nns_pkg::div_rsp_t            div_rsp;
    logic [nns_pkg::PIXEL_W-1:0]  ram_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= nns_pkg::DIM_W'(256);
            source_height_reg <= nns_pkg::DIM_W'(256);
            scale_factor_reg  <= nns_pkg::FACTOR_W'(256);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                nns_pkg::REG_SOURCE_WIDTH:
                begin
                    source_width_reg <= wr_data[nns_pkg::DIM_W-1:0];
                end
                nns_pkg::REG_SOURCE_HEIGHT:
                begin
                    source_height_reg <= wr_data[nns_pkg::DIM_W-1:0];
                end
                nns_pkg::REG_SCALE_FACTOR:
                begin
                    scale_factor_reg <= wr_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Effective geometry: clamp dimensions and factor, size the output image.
    always_comb
    begin
        if (source_width_reg == '0)
            width_eff = nns_pkg::DIM_W'(1);
        else if (source_width_reg > nns_pkg::DIM_W'(nns_pkg::MAX_WIDTH))
            width_eff = nns_pkg::DIM_W'(nns_pkg::MAX_WIDTH);
        else
            width_eff = source_width_reg;

        if (source_height_reg == '0)
            height_eff = nns_pkg::DIM_W'(1);
        else if (source_height_reg > nns_pkg::DIM_W'(nns_pkg::MAX_HEIGHT))
            height_eff = nns_pkg::DIM_W'(nns_pkg::MAX_HEIGHT);
        else
            height_eff = source_height_reg;

        factor_eff = (scale_factor_reg == '0) ? nns_pkg::FACTOR_W'(1) : scale_factor_reg;

        total       = PROD_W'(width_eff) * PROD_W'(height_eff);
        width_prod  = SCALE_W'(width_eff) * SCALE_W'(factor_eff);
        height_prod = SCALE_W'(height_eff) * SCALE_W'(factor_eff);

        if ((width_prod >> nns_pkg::FRAC_W) > SCALE_W'(nns_pkg::OUT_LIMIT))
            scaled_w = nns_pkg::OUT_W'(nns_pkg::OUT_LIMIT);
        else
            scaled_w = width_prod[nns_pkg::FRAC_W +: nns_pkg::OUT_W];

        if ((height_prod >> nns_pkg::FRAC_W) > SCALE_W'(nns_pkg::OUT_LIMIT))
            scaled_h = nns_pkg::OUT_W'(nns_pkg::OUT_LIMIT);
        else
            scaled_h = height_prod[nns_pkg::FRAC_W +: nns_pkg::OUT_W];
    end

    // Item acceptance and the load pointer.
    always_comb
    begin
        accept   = start && !busy;
        load_go  = accept && !operation;
        fetch_go = accept && operation && (scaled_w != '0) && (scaled_h != '0);

        ptr_eff  = (PROD_W'(load_ptr_reg) >= total) ? '0 : load_ptr_reg;
        ptr_inc  = PROD_W'(ptr_eff) + PROD_W'(1);
        ptr_next = (ptr_inc >= total) ? '0 : ptr_inc[nns_pkg::ADDR_W-1:0];
    end

    // Output position of this fetch and the position of the next one.
    always_comb
    begin
        restart   = (nns_pkg::OUT_W'(emit_row_reg) >= scaled_h) ||
                    (nns_pkg::OUT_W'(emit_col_reg) >= scaled_w);
        row_start = restart ? '0 : emit_row_reg;
        col_start = restart ? '0 : emit_col_reg;
        last_now  = (nns_pkg::OUT_W'(row_start) == scaled_h - 1'b1) &&
                    (nns_pkg::OUT_W'(col_start) == scaled_w - 1'b1);

        row_inc   = nns_pkg::OUT_W'(row_start) + 1'b1;
        col_inc   = nns_pkg::OUT_W'(col_start) + 1'b1;
        row_after = row_start;
        col_after = col_inc[nns_pkg::POS_W-1:0];
        if (col_inc >= scaled_w)
        begin
            col_after = '0;
            row_after = (row_inc >= scaled_h) ? '0 : row_inc[nns_pkg::POS_W-1:0];
        end
    end

    // Source index: quotient saturated at the last row or column.
    always_comb
    begin
        if (div_rsp.quotient >= nns_pkg::DIVIDEND_W'(height_eff))
            quo_row_sat = height_eff - 1'b1;
        else
            quo_row_sat = div_rsp.quotient[nns_pkg::DIM_W-1:0];

        if (div_rsp.quotient >= nns_pkg::DIVIDEND_W'(width_eff))
            quo_col_sat = width_eff - 1'b1;
        else
            quo_col_sat = div_rsp.quotient[nns_pkg::DIM_W-1:0];

        addr_full = PROD_W'(src_row_reg) * PROD_W'(width_eff) + PROD_W'(src_col_reg);
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nns_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer next state and controls.
    always_comb
    begin
        state_next      = state_reg;
        div_req.start   = 1'b0;
        div_sel_col     = 1'b0;
        ram_re          = 1'b0;
        unique case (state_reg)
            nns_pkg::S_IDLE:
            begin
                if (fetch_go)
                begin
                    div_req.start = 1'b1;
                    state_next    = nns_pkg::S_ROW_DIV;
                end
            end
            nns_pkg::S_ROW_DIV:
            begin
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_sel_col   = 1'b1;
                    state_next    = nns_pkg::S_COL_DIV;
                end
            end
            nns_pkg::S_COL_DIV:
            begin
                if (div_rsp.done)
                    state_next = nns_pkg::S_ADDR;
            end
            nns_pkg::S_ADDR:
            begin
                state_next = nns_pkg::S_READ;
            end
            nns_pkg::S_READ:
            begin
                ram_re     = 1'b1;
                state_next = nns_pkg::S_EMIT;
            end
            nns_pkg::S_EMIT:
            begin
                state_next = nns_pkg::S_IDLE;
            end
            default:
            begin
                state_next = nns_pkg::S_IDLE;
            end
        endcase
        div_req.dividend = div_sel_col ? {cur_col_reg, nns_pkg::FRAC_W'(0)}
                                       : {row_start, nns_pkg::FRAC_W'(0)};
        div_req.divisor  = factor_eff;
    end

    // Counters of the load and fetch rasters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
        end
        else
        begin
            if (load_go)
                load_ptr_reg <= ptr_next;
            if (fetch_go)
            begin
                emit_row_reg <= row_after;
                emit_col_reg <= col_after;
            end
        end
    end

    // Per-fetch payload registers.
    always_ff @(posedge clk)
    begin
        if (fetch_go)
        begin
            cur_row_reg <= row_start;
            cur_col_reg <= col_start;
            last_reg    <= last_now;
        end
        if (state_reg == nns_pkg::S_ROW_DIV && div_rsp.done)
            src_row_reg <= quo_row_sat;
        if (state_reg == nns_pkg::S_COL_DIV && div_rsp.done)
            src_col_reg <= quo_col_sat;
        if (state_reg == nns_pkg::S_ADDR)
            read_addr_reg <= addr_full[nns_pkg::ADDR_W-1:0];
    end

    // Shared divider for the row and column quotients.
    nns_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Frame store.
    nns_ram #(
        .WIDTH (nns_pkg::PIXEL_W),
        .DEPTH (nns_pkg::STORE_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (load_go),
        .waddr (ptr_eff),
        .wdata ({in_red, in_green, in_blue}),
        .re    (ram_re),
        .raddr (read_addr_reg),
        .rdata (ram_rdata)
    );

    // Result ports.
    assign busy       = (state_reg != nns_pkg::S_IDLE);
    assign done       = (state_reg == nns_pkg::S_EMIT);
    assign out_red    = ram_rdata[2*nns_pkg::CHAN_W +: nns_pkg::CHAN_W];
    assign out_green  = ram_rdata[nns_pkg::CHAN_W +: nns_pkg::CHAN_W];
    assign out_blue   = ram_rdata[0 +: nns_pkg::CHAN_W];
    assign out_row    = cur_row_reg;
    assign out_col    = cur_col_reg;
    assign last_pixel = last_reg;

endmodule

// File: src/nns_ram.sv
module nns_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/nns_div.sv
module nns_div (
    input  logic              clk,
    input  logic              rst_n,
    input  nns_pkg::div_req_t req,
    output nns_pkg::div_rsp_t rsp
);

    logic                           active_reg;
    logic                           done_reg;
    logic [nns_pkg::DIV_CNT_W-1:0]  count_reg;
    logic [nns_pkg::DIVIDEND_W-1:0] quo_reg;
    logic [nns_pkg::FACTOR_W-1:0]   rem_reg;
    logic [nns_pkg::FACTOR_W-1:0]   divisor_reg;

    logic [nns_pkg::FACTOR_W:0]     rem_shift;
    logic                           fits;
    logic [nns_pkg::FACTOR_W:0]     rem_diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[nns_pkg::DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, divisor_reg};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
    end

    // Control: runs one quotient bit per cycle and pulses done at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                count_reg  <= '0;
            end
            else if (active_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == nns_pkg::DIV_CNT_W'(nns_pkg::DIVIDEND_W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits replace dividend bits from the bottom up.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (active_reg)
        begin
            quo_reg <= {quo_reg[nns_pkg::DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? rem_diff[nns_pkg::FACTOR_W-1:0]
                            : rem_shift[nns_pkg::FACTOR_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: src/nns_checker.sv
module nns_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           operation,
    input logic [nns_pkg::CHAN_W-1:0]     in_red,
    input logic [nns_pkg::CHAN_W-1:0]     in_green,
    input logic [nns_pkg::CHAN_W-1:0]     in_blue,
    input logic                           wr_en,
    input logic [nns_pkg::INDEX_W-1:0]    wr_index,
    input logic [nns_pkg::WDATA_W-1:0]    wr_data,
    input logic                           done,
    input logic [nns_pkg::CHAN_W-1:0]     out_red,
    input logic [nns_pkg::CHAN_W-1:0]     out_green,
    input logic [nns_pkg::CHAN_W-1:0]     out_blue,
    input logic [nns_pkg::POS_W-1:0]      out_row,
    input logic [nns_pkg::POS_W-1:0]      out_col,
    input logic                           last_pixel
);

    // A result only appears while a fetch is in progress.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe outside a fetch");

    // The strobe lasts one cycle and the block is free right after it.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    // A load item never occupies the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !operation) |=> !busy)
        else $error("load item made the block busy");

    // A fetch only ends by delivering its result.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> $past(done))
        else $error("fetch ended without a result");

endmodule

bind nearest_neighbor_image_scaler nns_checker u_checker (.*);

// File: tb/nns_tb_pkg.sv
`timescale 1ns / 1ps
package nns_tb_pkg;

    // Operation codes carried on the operation port of an item.
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } scaler_op_t;

endpackage

// File: tb/nns_scaler_checker.sv
`timescale 1ns / 1ps
module nns_scaler_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           operation,
    input  logic [nns_pkg::CHAN_W-1:0]     in_red,
    input  logic [nns_pkg::CHAN_W-1:0]     in_green,
    input  logic [nns_pkg::CHAN_W-1:0]     in_blue,
    input  logic                           wr_en,
    input  logic [nns_pkg::INDEX_W-1:0]    wr_index,
    input  logic [nns_pkg::WDATA_W-1:0]    wr_data,
    input  logic                           done,
    input  logic [nns_pkg::CHAN_W-1:0]     out_red,
    input  logic [nns_pkg::CHAN_W-1:0]     out_green,
    input  logic [nns_pkg::CHAN_W-1:0]     out_blue,
    input  logic [nns_pkg::POS_W-1:0]      out_row,
    input  logic [nns_pkg::POS_W-1:0]      out_col,
    input  logic                           last_pixel,
    output int                             mismatch_count,
    output int                             expected_left
);
    import nns_pkg::*;
    import nns_tb_pkg::*;

    // One pixel of the scaled image as the block should deliver it.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } scaled_pixel_t;

    // Shadow copy of the block state and registers.
    logic [PIXEL_W-1:0]  shadow_store [STORE_DEPTH];
    int unsigned         load_ptr;
    int unsigned         emit_row;
    int unsigned         emit_col;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [FACTOR_W-1:0] factor_reg;

    scaled_pixel_t pending_pixels[$];
    int            fail_tally   = 0;
    int            pending_now  = 0;

    assign mismatch_count = fail_tally;
    assign expected_left  = pending_now;

    // A zero dimension counts as one; larger values saturate at the maximum dimension.
    function automatic int unsigned effective_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned lim);
        if (v == '0)
            return 1;
        return (v > lim) ? lim : int'(v);
    endfunction

    // Size of one scaled dimension, saturated at the counter range.
    function automatic int unsigned scaled_extent(input int unsigned dim,
                                                  input int unsigned fac);
        int unsigned s;
        s = (dim * fac) >> FRAC_W;
        return (s > OUT_LIMIT) ? OUT_LIMIT : s;
    endfunction

    // Source row or column for a scaled position, held inside the image.
    function automatic int unsigned source_coord(input int unsigned pos,
                                                 input int unsigned fac,
                                                 input int unsigned dim);
        int unsigned s;
        s = (pos << FRAC_W) / fac;
        return (s >= dim) ? dim - 1 : s;
    endfunction

    task automatic flag_error(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        fail_tally++;
    endtask

    task automatic compare_field(input string name, input logic [POS_W-1:0] got,
                                 input logic [POS_W-1:0] want,
                                 input scaled_pixel_t ref_px);
        if (got !== want)
            flag_error($sformatf("%s of pixel (%0d,%0d): got %0h, expected %0h",
                                 name, ref_px.row, ref_px.col, got, want));
    endtask

    // Apply one accepted item to the shadow state.
    task automatic apply_item(input logic op, input logic [PIXEL_W-1:0] px_in);
        int unsigned   w;
        int unsigned   h;
        int unsigned   fac;
        int unsigned   total;
        int unsigned   ow;
        int unsigned   oh;
        int unsigned   sr;
        int unsigned   sc;
        scaled_pixel_t px;
        w     = effective_dim(width_reg, MAX_WIDTH);
        h     = effective_dim(height_reg, MAX_HEIGHT);
        fac   = (factor_reg == '0) ? 1 : int'(factor_reg);
        total = w * h;
        if (op == OP_LOAD) begin
            if (load_ptr >= total)
                load_ptr = 0;
            shadow_store[load_ptr] = px_in;
            load_ptr++;
            if (load_ptr >= total)
                load_ptr = 0;
        end
        else begin
            ow = scaled_extent(w, fac);
            oh = scaled_extent(h, fac);
            // An empty scaled image yields nothing and keeps the counters.
            if (ow != 0 && oh != 0) begin
                if (emit_row >= oh || emit_col >= ow) begin
                    emit_row = 0;
                    emit_col = 0;
                end
                sr = source_coord(emit_row, fac, h);
                sc = source_coord(emit_col, fac, w);
                {px.red, px.green, px.blue} = shadow_store[sr * w + sc];
                px.row  = emit_row[POS_W-1:0];
                px.col  = emit_col[POS_W-1:0];
                px.last = (emit_row == oh - 1) && (emit_col == ow - 1);
                pending_pixels.push_back(px);
                emit_col++;
                if (emit_col >= ow) begin
                    emit_col = 0;
                    emit_row++;
                    if (emit_row >= oh)
                        emit_row = 0;
                end
            end
        end
    endtask

    // Compare one delivered pixel with the oldest expected one.
    task automatic check_result();
        scaled_pixel_t want;
        if (pending_pixels.size() == 0) begin
            flag_error($sformatf("result at (%0d,%0d) with nothing expected",
                                 out_row, out_col));
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("out_red",    POS_W'(out_red),    POS_W'(want.red),   want);
        compare_field("out_green",  POS_W'(out_green),  POS_W'(want.green), want);
        compare_field("out_blue",   POS_W'(out_blue),   POS_W'(want.blue),  want);
        compare_field("out_row",    out_row,            want.row,           want);
        compare_field("out_col",    out_col,            want.col,           want);
        compare_field("last_pixel", POS_W'(last_pixel), POS_W'(want.last),  want);
    endtask

    // Results are checked before a new item is applied in the same cycle,
    // since a result always belongs to an earlier item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            load_ptr   = 0;
            emit_row   = 0;
            emit_col   = 0;
            width_reg  = DIM_W'(MAX_WIDTH);
            height_reg = DIM_W'(MAX_HEIGHT);
            factor_reg = FACTOR_W'(1 << FRAC_W);
            pending_pixels.delete();
        end
        else begin
            if (done)
                check_result();
            if (wr_en) begin
                case (wr_index)
                    REG_SOURCE_WIDTH:  width_reg  = wr_data[DIM_W-1:0];
                    REG_SOURCE_HEIGHT: height_reg = wr_data[DIM_W-1:0];
                    REG_SCALE_FACTOR:  factor_reg = wr_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                apply_item(operation, {in_red, in_green, in_blue});
        end
        pending_now = pending_pixels.size();
    end

endmodule

// File: tb/tb_nearest_neighbor_image_scaler.sv
`timescale 1ns / 1ps
module tb_nearest_neighbor_image_scaler;
    import nns_pkg::*;
    import nns_tb_pkg::*;

    // Settling time before a register write, after the block is idle.
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 2000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                operation;
    logic [CHAN_W-1:0]   in_red;
    logic [CHAN_W-1:0]   in_green;
    logic [CHAN_W-1:0]   in_blue;
    logic                wr_en;
    logic [INDEX_W-1:0]  wr_index;
    logic [WDATA_W-1:0]  wr_data;
    logic                busy;
    logic                done;
    logic [CHAN_W-1:0]   out_red;
    logic [CHAN_W-1:0]   out_green;
    logic [CHAN_W-1:0]   out_blue;
    logic [POS_W-1:0]    out_row;
    logic [POS_W-1:0]    out_col;
    logic                last_pixel;

    int mismatch_count;
    int expected_left;
    int quiet_cycles  = 0;
    int idle_pct      = 0;
    int loaded_prefix = 0;
    int idle_levels [3] = '{0, 53, 26};

    nearest_neighbor_image_scaler DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .done       (done),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_row    (out_row),
        .out_col    (out_col),
        .last_pixel (last_pixel)
    );

    nns_scaler_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .in_red         (in_red),
        .in_green       (in_green),
        .in_blue        (in_blue),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .done           (done),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .out_row        (out_row),
        .out_col        (out_col),
        .last_pixel     (last_pixel),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Watchdog: give up when neither an item nor a result moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Channel values lean toward the extremes.
    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    // Mostly moderate factors, now and then anything the register holds.
    function automatic logic [FACTOR_W-1:0] pick_factor();
        case ($urandom_range(7))
            0:       return FACTOR_W'($urandom_range(0, 4095));
            1, 2:    return FACTOR_W'($urandom_range(128, 256));
            default: return FACTOR_W'($urandom_range(256, 768));
        endcase
    endfunction

    // Offer one item, after an optional idle gap, and return at the edge that takes it.
    task automatic send_item(input scaler_op_t op);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start     <= 1'b1;
        operation <= op;
        in_red    <= pick_channel();
        in_green  <= pick_channel();
        in_blue   <= pick_channel();
        do
            @(posedge clk);
        while (busy);
    endtask

    // Wait until every expected pixel is in and the block has settled.
    task automatic wait_quiet();
        start <= 1'b0;
        @(negedge clk);
        while (expected_left != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [DIM_W-1:0] w_val,
                                input logic [DIM_W-1:0] h_val,
                                input logic [FACTOR_W-1:0] f_val);
        wr_en    <= 1'b1;
        wr_index <= REG_SOURCE_WIDTH;
        wr_data  <= WDATA_W'(w_val);
        @(posedge clk);
        wr_index <= REG_SOURCE_HEIGHT;
        wr_data  <= WDATA_W'(h_val);
        @(posedge clk);
        wr_index <= REG_SCALE_FACTOR;
        wr_data  <= f_val;
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    // One setting: program it, make sure every pixel a fetch can read has been
    // loaded, then a fetch-heavy mix of items.
    task automatic run_phase(input logic [DIM_W-1:0] w_val,
                             input logic [DIM_W-1:0] h_val,
                             input logic [FACTOR_W-1:0] f_val,
                             input int mixed_items, input int idle_level);
        int w_eff;
        int h_eff;
        wait_quiet();
        program_regs(w_val, h_val, f_val);
        idle_pct = idle_level;
        w_eff = (w_val == 0) ? 1 : ((w_val > MAX_WIDTH) ? MAX_WIDTH : int'(w_val));
        h_eff = (h_val == 0) ? 1 : ((h_val > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_val));
        // A run of width*height loads covers every address below that count,
        // wherever the load pointer starts.
        if (w_eff * h_eff > loaded_prefix)
        begin
            repeat (w_eff * h_eff) send_item(OP_LOAD);
            loaded_prefix = w_eff * h_eff;
        end
        repeat (mixed_items)
        begin
            if ($urandom_range(99) < 75)
                send_item(OP_FETCH);
            else
                send_item(OP_LOAD);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_LOAD;
        in_red    = '0;
        in_green  = '0;
        in_blue   = '0;
        wr_en     = 1'b0;
        wr_index  = REG_SOURCE_WIDTH;
        wr_data   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a 2x2 identity image that wraps, a zero width upscaled,
        // and a zero factor giving an empty scaled image.
        run_phase(9'd2, 9'd2, 12'd256, 5, idle_levels[0]);
        run_phase(9'd0, 9'd3, 12'd512, 6, idle_levels[0]);
        run_phase(9'd5, 9'd1, 12'd0, 3, idle_levels[0]);

        // Register extremes: full and saturated width and height, largest and smallest factor.
        run_phase(9'd256, 9'd1, 12'd256, 20, idle_levels[2]);
        run_phase(9'd1, 9'd256, 12'd4095, 20, idle_levels[1]);
        run_phase(9'd511, 9'd1, 12'd700, 15, idle_levels[0]);
        run_phase(9'd1, 9'd511, 12'd600, 15, idle_levels[1]);
        run_phase(9'd7, 9'd3, 12'd1, 6, idle_levels[2]);

        // Small images with random settings, so the counters wrap often.
        for (int p = 0; p < 8; p++)
        begin
            run_phase(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)),
                      pick_factor(), 12, idle_levels[p % 3]);
        end

        wait_quiet();
        @(negedge clk);
        if (mismatch_count == 0 && expected_left == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
src/nns_pkg.sv
src/nns_ram.sv
src/nns_div.sv
src/nearest_neighbor_image_scaler.sv
src/nns_checker.sv
tb/nns_tb_pkg.sv
tb/nns_scaler_checker.sv
tb/tb_nearest_neighbor_image_scaler.sv
